[src/ssbt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssbt_pkg
// Shared types and constants of the stable sorted bid table.
// ----------------------------------------------------------------------------
package ssbt_pkg;

    // table depth; a power of two, so logical-to-physical slot math wraps
    localparam int DEPTH = 64;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = IDX_W + 1;

    localparam int Q_W   = 32;
    localparam int P_W   = 32;
    localparam int SUM_W = 38;
    localparam int ECNT_W = 7;

    localparam int CFG_IDX_W = 2;

    typedef enum logic [1:0] {
        OP_INSERT  = 2'd0,
        OP_POP_MIN = 2'd1,
        OP_POP_MAX = 2'd2,
        OP_CLEAR   = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NEGATE_PRICE    = 2'd0,
        REG_NEGATE_QUANTITY = 2'd1
    } t_reg;

    typedef struct packed {
        logic [Q_W-1:0] quantity;
        logic [P_W-1:0] price;
    } t_entry;

endpackage
`default_nettype wire

[src/stable_sorted_bid_table_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stable_sorted_bid_table_core
// Bid table kept sorted by ascending price, stable for equal prices, with
// insert, pop smallest, pop largest and clear.
// ----------------------------------------------------------------------------
// channel   direction  handshake                    payload
// command   in         start high, busy low         operation, bid_quantity, bid_price
// result    out        o_result_strobe, one cycle   popped fields, flags, count, total
// config    in         i_cfg_valid && o_cfg_ready   i_cfg_index, i_cfg_data
//
// Bids sit in a circular buffer (one-write, one-read memory with registered
// read data) with a head pointer, so popping either end moves no entries.
// An insert walks from the back, moving each larger-priced entry up one slot
// per cycle through the single write port; into an empty table the bid is
// placed directly at the head.
// Clear, empty pops and dropped inserts finish without leaving idle.
// Synchronous active-low reset empties the table; no clearing pass is needed.
// The receiver cannot stall; the result strobe lasts exactly one cycle.
// ----------------------------------------------------------------------------
module stable_sorted_bid_table_core
    import ssbt_pkg::*;
(
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        start,
    output logic                       busy,
    input  wire  [1:0]                 i_operation,
    input  wire  signed [Q_W-1:0]      i_bid_quantity,
    input  wire  signed [P_W-1:0]      i_bid_price,
    output logic                       o_result_strobe,
    output logic signed [Q_W-1:0]      o_popped_quantity,
    output logic signed [P_W-1:0]      o_popped_price,
    output logic                       o_popped_valid,
    output logic                       o_insert_dropped,
    output logic [ECNT_W-1:0]          o_entry_count,
    output logic signed [SUM_W-1:0]    o_total_quantity,
    input  wire                        i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire  [CFG_IDX_W-1:0]       i_cfg_index,
    input  wire                        i_cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_INS_SCAN,
        S_INS_PLACE,
        S_POP
    } t_state;

    t_entry r_mem [DEPTH];
    t_entry r_rd;

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_head, n_head;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [SUM_W-1:0]   r_sum, n_sum;
    logic [IDX_W-1:0]   r_k, n_k;
    t_op                r_op, n_op;
    t_entry             r_bid, n_bid;
    logic               r_neg_price, r_neg_quantity;
    logic               r_strobe, n_strobe;
    logic [Q_W-1:0]     r_out_q, n_out_q;
    logic [P_W-1:0]     r_out_p, n_out_p;
    logic               r_out_valid, n_out_valid;
    logic               r_out_drop, n_out_drop;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_log;
    t_entry             wr_data;
    logic [IDX_W-1:0]   rd_log;

    // shared add/subtract on the running total
    logic               sum_sub;
    logic [Q_W-1:0]     sum_operand;
    logic [SUM_W-1:0]   sum_ext;
    logic [SUM_W-1:0]   sum_result;

    logic               accept;
    logic               rd_greater;
    logic [IDX_W-1:0]   last_log;

    assign accept     = start && !busy;
    assign last_log   = r_count[IDX_W-1:0] - IDX_W'(1);
    assign rd_greater = $signed(r_rd.price) > $signed(r_bid.price);

    assign sum_ext    = {{(SUM_W-Q_W){sum_operand[Q_W-1]}}, sum_operand};
    assign sum_result = sum_sub ? (r_sum - sum_ext) : (r_sum + sum_ext);

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_sum       = r_sum;
        n_k         = r_k;
        n_op        = r_op;
        n_bid       = r_bid;
        n_strobe    = 1'b0;
        n_out_q     = r_out_q;
        n_out_p     = r_out_p;
        n_out_valid = r_out_valid;
        n_out_drop  = r_out_drop;
        wr_en       = 1'b0;
        wr_log      = '0;
        wr_data     = r_bid;
        rd_log      = r_k - IDX_W'(1);
        sum_sub     = 1'b0;
        sum_operand = r_bid.quantity;

        case (r_state)
            S_IDLE: begin
                rd_log = (t_op'(i_operation) == OP_POP_MIN) ? '0 : last_log;
                if (accept) begin
                    n_op        = t_op'(i_operation);
                    n_bid       = '{quantity: i_bid_quantity, price: i_bid_price};
                    n_k         = last_log;
                    n_out_q     = '0;
                    n_out_p     = '0;
                    n_out_valid = 1'b0;
                    n_out_drop  = 1'b0;
                    case (t_op'(i_operation))
                        OP_INSERT: begin
                            if (r_count >= CNT_W'(DEPTH)) begin
                                n_out_drop = 1'b1;
                                n_strobe   = 1'b1;
                            end else if (r_count == '0) begin
                                // empty table: place directly at the head
                                wr_en       = 1'b1;
                                wr_log      = '0;
                                wr_data     = n_bid;
                                sum_operand = i_bid_quantity;
                                n_sum       = sum_result;
                                n_count     = r_count + CNT_W'(1);
                                n_strobe    = 1'b1;
                            end else begin
                                n_state = S_INS_SCAN;
                            end
                        end
                        OP_POP_MIN, OP_POP_MAX: begin
                            if (r_count == '0) begin
                                n_strobe = 1'b1;
                            end else begin
                                n_state = S_POP;
                            end
                        end
                        default: begin
                            n_count  = '0;
                            n_sum    = '0;
                            n_head   = '0;
                            n_strobe = 1'b1;
                        end
                    endcase
                end
            end
            S_INS_SCAN: begin
                // r_rd holds logical entry r_k
                wr_en  = 1'b1;
                wr_log = r_k + IDX_W'(1);
                if (rd_greater) begin
                    wr_data = r_rd;
                    n_k     = r_k - IDX_W'(1);
                    if (r_k == '0) begin
                        n_state = S_INS_PLACE;
                    end
                end else begin
                    wr_data  = r_bid;
                    n_sum    = sum_result;
                    n_count  = r_count + CNT_W'(1);
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_INS_PLACE: begin
                wr_en    = 1'b1;
                wr_log   = '0;
                wr_data  = r_bid;
                n_sum    = sum_result;
                n_count  = r_count + CNT_W'(1);
                n_strobe = 1'b1;
                n_state  = S_IDLE;
            end
            S_POP: begin
                sum_sub     = 1'b1;
                sum_operand = r_rd.quantity;
                n_sum       = sum_result;
                n_count     = r_count - CNT_W'(1);
                if (r_op == OP_POP_MIN) begin
                    n_head = r_head + IDX_W'(1);
                end
                n_out_q     = r_neg_quantity ? (Q_W'(0) - r_rd.quantity) : r_rd.quantity;
                n_out_p     = r_neg_price ? (P_W'(0) - r_rd.price) : r_rd.price;
                n_out_valid = 1'b1;
                n_strobe    = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // table storage: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_head + wr_log] <= wr_data;
        end
        r_rd <= r_mem[r_head + rd_log];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_head         <= '0;
            r_count        <= '0;
            r_sum          <= '0;
            r_strobe       <= 1'b0;
            r_out_valid    <= 1'b0;
            r_out_drop     <= 1'b0;
            r_neg_price    <= 1'b0;
            r_neg_quantity <= 1'b0;
            r_out_q        <= '0;
            r_out_p        <= '0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_sum       <= n_sum;
            r_strobe    <= n_strobe;
            r_out_q     <= n_out_q;
            r_out_p     <= n_out_p;
            r_out_valid <= n_out_valid;
            r_out_drop  <= n_out_drop;
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_reg'(i_cfg_index))
                    REG_NEGATE_PRICE:    r_neg_price    <= i_cfg_data;
                    REG_NEGATE_QUANTITY: r_neg_quantity <= i_cfg_data;
                    default: ;
                endcase
            end
        end
        r_k   <= n_k;
        r_op  <= n_op;
        r_bid <= n_bid;
    end

    assign busy              = (r_state != S_IDLE);
    assign o_cfg_ready       = 1'b1;
    assign o_result_strobe   = r_strobe;
    assign o_popped_quantity = r_out_q;
    assign o_popped_price    = r_out_p;
    assign o_popped_valid    = r_out_valid;
    assign o_insert_dropped  = r_out_drop;
    assign o_entry_count     = ECNT_W'(r_count);
    assign o_total_quantity  = r_sum;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count beyond table depth");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> !busy)
        else $error("result shown while an item is still at work");

    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_out_drop) |-> (r_count == CNT_W'(DEPTH)))
        else $error("insert dropped while table not full");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |=> (r_strobe && r_out_valid && !busy))
        else $error("pop did not finish with a valid result");

endmodule
`default_nettype wire

[dv/bid_table_scoreboard_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bid_table_scoreboard_pkg
// Scoreboard for the sorted bid table: keeps its own copy of the table and
// the negate flags, works out the outcome of every accepted command and
// checks each result strobe against the oldest outcome still due.
// ----------------------------------------------------------------------------
package bid_table_scoreboard_pkg;
    import ssbt_pkg::*;

    typedef struct packed {
        logic signed [Q_W-1:0]   quantity;
        logic signed [P_W-1:0]   price;
        logic                    valid;
        logic                    dropped;
        logic [ECNT_W-1:0]       count;
        logic signed [SUM_W-1:0] total;
    } t_outcome;

    class bid_table_scoreboard;
        logic [Q_W-1:0]   book_qty[DEPTH];
        logic [P_W-1:0]   book_price[DEPTH];
        int               book_size;
        logic [SUM_W-1:0] book_total;
        logic             neg_price;
        logic             neg_qty;
        t_outcome         outcomes_due[$];
        int               errors;
        int               items;
        int               live_pops;
        int               empty_pops;
        int               drops;
        int               clears;
        int               peak_size;

        function new();
            book_size  = 0;
            book_total = '0;
            neg_price  = 1'b0;
            neg_qty    = 1'b0;
            errors     = 0;
            items      = 0;
            live_pops  = 0;
            empty_pops = 0;
            drops      = 0;
            clears     = 0;
            peak_size  = 0;
        endfunction

        function int pending();
            return outcomes_due.size();
        endfunction

        function int held();
            return book_size;
        endfunction

        // unknown indexes are ignored by the block
        function void write_register(logic [CFG_IDX_W-1:0] idx, logic value);
            case (idx)
                REG_NEGATE_PRICE:    neg_price = value;
                REG_NEGATE_QUANTITY: neg_qty   = value;
                default: ;
            endcase
        endfunction

        function void note_command(t_op op, logic [Q_W-1:0] qty, logic [P_W-1:0] price);
            t_outcome o;
            int       pos;
            o = '0;
            items++;
            case (op)
                OP_INSERT: begin
                    if (book_size >= DEPTH) begin
                        o.dropped = 1'b1;
                        drops++;
                    end else begin
                        // new bid lands after every equal price
                        pos = 0;
                        while (pos < book_size &&
                               $signed(book_price[pos]) <= $signed(price))
                            pos++;
                        for (int i = book_size; i > pos; i--) begin
                            book_qty[i]   = book_qty[i-1];
                            book_price[i] = book_price[i-1];
                        end
                        book_qty[pos]   = qty;
                        book_price[pos] = price;
                        book_size++;
                        book_total = book_total + {{(SUM_W-Q_W){qty[Q_W-1]}}, qty};
                        if (book_size > peak_size)
                            peak_size = book_size;
                    end
                end
                OP_POP_MIN, OP_POP_MAX: begin
                    if (book_size == 0) begin
                        empty_pops++;
                    end else begin
                        if (op == OP_POP_MIN) begin
                            o.quantity = book_qty[0];
                            o.price    = book_price[0];
                            for (int i = 1; i < book_size; i++) begin
                                book_qty[i-1]   = book_qty[i];
                                book_price[i-1] = book_price[i];
                            end
                        end else begin
                            o.quantity = book_qty[book_size-1];
                            o.price    = book_price[book_size-1];
                        end
                        book_size--;
                        book_total = book_total -
                                     {{(SUM_W-Q_W){o.quantity[Q_W-1]}}, o.quantity};
                        o.valid = 1'b1;
                        live_pops++;
                        // negation wraps, so the most negative value comes back as is
                        if (neg_qty)
                            o.quantity = -o.quantity;
                        if (neg_price)
                            o.price = -o.price;
                    end
                end
                default: begin
                    book_size  = 0;
                    book_total = '0;
                    clears++;
                end
            endcase
            o.count = ECNT_W'(book_size);
            o.total = book_total;
            outcomes_due.push_back(o);
        endfunction

        function void report(string msg);
            errors++;
            $display("mismatch: %s", msg);
        endfunction

        function void check_result(t_outcome got);
            t_outcome want;
            if (outcomes_due.size() == 0) begin
                report("result strobe with no command outstanding");
                return;
            end
            want = outcomes_due.pop_front();
            if (got.quantity !== want.quantity)
                report($sformatf("popped quantity %0d, expected %0d",
                                 got.quantity, want.quantity));
            if (got.price !== want.price)
                report($sformatf("popped price %0d, expected %0d",
                                 got.price, want.price));
            if (got.valid !== want.valid)
                report($sformatf("popped valid %0b, expected %0b", got.valid, want.valid));
            if (got.dropped !== want.dropped)
                report($sformatf("insert dropped %0b, expected %0b",
                                 got.dropped, want.dropped));
            if (got.count !== want.count)
                report($sformatf("entry count %0d, expected %0d", got.count, want.count));
            if (got.total !== want.total)
                report($sformatf("total quantity %0d, expected %0d",
                                 got.total, want.total));
        endfunction
    endclass

endpackage

[dv/stable_sorted_bid_table_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_sorted_bid_table_core_test
// Drives insert, pop and clear commands into the bid table under all four
// negate settings, with directed corner bids, full-table fills and random
// mixes, and checks every result strobe against the scoreboard.
// ----------------------------------------------------------------------------
module stable_sorted_bid_table_core_test;
    import ssbt_pkg::*;
    import bid_table_scoreboard_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    logic [1:0]              i_operation;
    logic [Q_W-1:0]          i_bid_quantity;
    logic [P_W-1:0]          i_bid_price;
    logic                    o_result_strobe;
    logic signed [Q_W-1:0]   o_popped_quantity;
    logic signed [P_W-1:0]   o_popped_price;
    logic                    o_popped_valid;
    logic                    o_insert_dropped;
    logic [ECNT_W-1:0]       o_entry_count;
    logic signed [SUM_W-1:0] o_total_quantity;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index;
    logic                    i_cfg_data;

    bid_table_scoreboard sb;
    bit                  gaps_on;
    int unsigned         cycle_count = 0;

    stable_sorted_bid_table_core i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_operation       (i_operation),
        .i_bid_quantity    (i_bid_quantity),
        .i_bid_price       (i_bid_price),
        .o_result_strobe   (o_result_strobe),
        .o_popped_quantity (o_popped_quantity),
        .o_popped_price    (o_popped_price),
        .o_popped_valid    (o_popped_valid),
        .o_insert_dropped  (o_insert_dropped),
        .o_entry_count     (o_entry_count),
        .o_total_quantity  (o_total_quantity),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_strobe)
            sb.check_result({o_popped_quantity, o_popped_price, o_popped_valid,
                             o_insert_dropped, o_entry_count, o_total_quantity});
    end

    function automatic logic [31:0] pick_word();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // crowded prices mostly sit in a narrow band so equal prices are common
    function automatic logic [31:0] pick_price(bit crowded);
        if (crowded && $urandom_range(3) != 0)
            return 32'(int'($urandom_range(6)) - 3);
        return pick_word();
    endfunction

    // called at a falling edge, returns at a falling edge with start left high
    task automatic send(t_op op, logic [Q_W-1:0] qty, logic [P_W-1:0] price);
        while (gaps_on && $urandom_range(99) < 12) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start          <= 1'b1;
        i_operation    <= op;
        i_bid_quantity <= qty;
        i_bid_price    <= price;
        do @(posedge i_clk); while (busy);
        sb.note_command(op, qty, price);
        @(negedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic cfg_beat(logic [CFG_IDX_W-1:0] idx, logic value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_register(idx, value);
        @(negedge i_clk);
    endtask

    // only called with the table idle
    task automatic configure(logic neg_p, logic neg_q);
        cfg_beat(REG_SPARE_LO, 1'($urandom));
        cfg_beat(REG_NEGATE_PRICE, neg_p);
        cfg_beat(REG_NEGATE_QUANTITY, neg_q);
        cfg_beat(REG_SPARE_HI, 1'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic opening_checks();
        send(OP_POP_MIN, $urandom, $urandom);
        send(OP_POP_MAX, $urandom, $urandom);
        send(OP_INSERT, 32'h7fff_ffff, 32'h7fff_ffff);
        send(OP_INSERT, 32'h8000_0000, 32'h8000_0000);
        send(OP_INSERT, 32'h0000_0000, 32'h0000_0000);
        send(OP_INSERT, 32'hffff_ffff, 32'hffff_ffff);
        // equal prices must leave in arrival order
        send(OP_INSERT, 32'd11, 32'd5);
        send(OP_INSERT, 32'd12, 32'd5);
        send(OP_INSERT, 32'd13, 32'd5);
        repeat (5) send(OP_POP_MIN, $urandom, $urandom);
        send(OP_INSERT, 32'd21, 32'd5);
        repeat (3) send(OP_POP_MAX, $urandom, $urandom);
        send(OP_INSERT, 32'd1, 32'd1);
        send(OP_CLEAR, $urandom, $urandom);
        send(OP_POP_MIN, $urandom, $urandom);
        send(OP_INSERT, 32'hffff_ffff, 32'd0);
        send(OP_POP_MAX, $urandom, $urandom);
    endtask

    // most negative values through the negate path, then an empty pop
    task automatic edge_pops();
        send(OP_CLEAR, $urandom, $urandom);
        send(OP_INSERT, 32'h8000_0000, 32'h8000_0000);
        send(OP_INSERT, 32'h7fff_ffff, 32'h7fff_ffff);
        send(OP_POP_MIN, $urandom, $urandom);
        send(OP_POP_MAX, $urandom, $urandom);
        send(OP_POP_MAX, $urandom, $urandom);
    endtask

    task automatic fill_to_full();
        while (sb.held() < DEPTH)
            send(OP_INSERT, pick_word(), pick_price(1'b1));
        repeat (3) send(OP_INSERT, pick_word(), pick_price(1'b0));
    endtask

    task automatic run_mix(int n, int insert_pct, bit crowded);
        t_op op;
        int  r;
        repeat (n) begin
            r = $urandom_range(99);
            if (r < insert_pct)
                op = OP_INSERT;
            else if (r < 97)
                op = ($urandom_range(1) != 0) ? OP_POP_MIN : OP_POP_MAX;
            else
                op = OP_CLEAR;
            send(op, pick_word(), pick_price(crowded));
        end
    endtask

    initial begin
        start          <= 1'b0;
        i_operation    <= OP_INSERT;
        i_bid_quantity <= '0;
        i_bid_price    <= '0;
        i_cfg_valid    <= 1'b0;
        i_cfg_index    <= REG_NEGATE_PRICE;
        i_cfg_data     <= 1'b0;
        i_rst_n        <= 1'b0;
        gaps_on = 1'b1;
        sb = new();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        configure(1'b0, 1'b0);
        opening_checks();
        run_mix(120, 55, 1'b1);
        fill_to_full();
        run_mix(60, 25, 1'b0);
        drain();

        configure(1'b1, 1'b0);
        edge_pops();
        run_mix(150, 60, 1'b1);
        drain();
        run_mix(40, 30, 1'b0);
        drain();

        // back-to-back commands with no sender gaps
        configure(1'b0, 1'b1);
        gaps_on = 1'b0;
        edge_pops();
        run_mix(150, 55, 1'b0);
        gaps_on = 1'b1;
        drain();

        configure(1'b1, 1'b1);
        edge_pops();
        fill_to_full();
        run_mix(100, 35, 1'b1);
        drain();

        repeat (70) @(posedge i_clk);
        $display("covered %0d commands: %0d bids popped, %0d empty pops, %0d refused inserts, %0d clears",
                 sb.items, sb.live_pops, sb.empty_pops, sb.drops, sb.clears);
        $display("table reached %0d of %0d entries, all four negate settings, %0d cycles",
                 sb.peak_size, DEPTH, cycle_count);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
